>>> rtl/dtep_pkg.sv
// Shared types and constants of the dash-depth tree edge parser.
package dtep_pkg;

	localparam int IndexBits = 16;
	localparam int ValueBits = 31;
	localparam int DepthBits = 8;
	localparam int ProdBits  = ValueBits + 4;

	localparam logic [DepthBits-1:0] DepthMax = 8'd255;
	localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};

	localparam logic [7:0] CharDash = 8'h2D;
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;

	localparam logic [1:0] SideNone  = 2'd0;
	localparam logic [1:0] SideLeft  = 2'd1;
	localparam logic [1:0] SideRight = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [IndexBits-1:0] node_index;
		logic [ValueBits-1:0] node_value;
		logic [DepthBits-1:0] node_depth;
		logic [IndexBits-1:0] parent_index;
		logic [1:0]           side;
		logic                 overflow;
		logic                 end_of_string;
		logic                 last_of_run;
	} out_item_t;

	// One finished node as the parser hands it on.
	typedef struct packed {
		logic [DepthBits-1:0] depth;
		logic [ValueBits-1:0] value;
	} node_cmd_t;

	// Everything one byte asks of the tree builder.
	typedef struct packed {
		logic      a_valid;
		node_cmd_t a;
		logic      b_valid;
		node_cmd_t b;
		logic      clear;
	} cmd_t;

endpackage

>>> rtl/dash_depth_tree_edge_parser_top.sv
// Top level of the dash-depth tree edge parser.
//
// The parser reads a preorder tree string one byte per clock cycle and writes one edge record
// for every node it finishes: index, value, depth, parent index and side. A node's depth is
// the number of dashes in front of it and its value the decimal digits after them; bytes that
// are neither are skipped. Input bytes are taken every cycle while full is low; full only rises
// when the four-entry queue between the byte classifier and the tree builder fills, which
// happens only if results are not popped. The tree builder handles one byte's work per cycle
// while the output queue has room, except for a byte that finishes two nodes (a dash after digits
// that is also the last byte of the string), which it handles in two passes. A record passes from the
// command queue through the tree builder's register stage into a four-entry output queue, where
// it waits until popped. The path stack holds STACK_DEPTH entries in a memory with a registered
// read port; a node that finds the stack full is still reported, with overflow set, but is not
// pushed. Node indexes stop at all ones, again with overflow set. The last byte of a string
// resets the classifier state, the path length and the node count, so the next string starts
// again at index zero. Stack contents are never cleared: every entry is written before it is used.
module dash_depth_tree_edge_parser_top #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  dtep_pkg::in_item_t  in_data,
	output logic                empty,
	input  logic                pop,
	output dtep_pkg::out_item_t out_data
);

	logic                cmd_push;
	dtep_pkg::cmd_t      cmd_in;
	dtep_pkg::cmd_t      cmd_head;
	logic                cmd_full;
	logic                cmd_empty;
	logic                cmd_pop;
	logic                res_push;
	dtep_pkg::out_item_t res;
	logic                res_full;

	assign full = cmd_full;

	// Classifies each accepted byte and keeps the node being read.
	dtep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push && !cmd_full),
		.in_data  (in_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Decouples the classifier from the tree builder.
	dtep_fifo #(
		.item_t (dtep_pkg::cmd_t),
		.Depth  (4)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// Attaches nodes to the path and forms the records.
	dtep_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Holds finished records until the consumer pops them.
	dtep_fifo #(
		.item_t (dtep_pkg::out_item_t),
		.Depth  (4)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_data),
		.empty  (empty)
	);

endmodule

>>> rtl/dtep_fifo.sv
// Small first-word-fall-through queue built from flip-flops.
module dtep_fifo #(
	parameter type item_t = logic,
	parameter int  Depth  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t             mem_q [Depth];
	logic [PtrW-1:0]   wptr_q;
	logic [PtrW-1:0]   rptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/dtep_front.sv
// Byte classifier: counts dashes, accumulates digits and hands finished nodes on.
module dtep_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  dtep_pkg::in_item_t in_data,
	output logic              cmd_push,
	output dtep_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_DASH  = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	phase_t                             phase_q;
	phase_t                             phase_d;
	logic [dtep_pkg::DepthBits-1:0]     dash_q;
	logic [dtep_pkg::DepthBits-1:0]     dash_d;
	logic [dtep_pkg::DepthBits-1:0]     dash_base;
	logic [dtep_pkg::ValueBits-1:0]     value_q;
	logic [dtep_pkg::ValueBits-1:0]     value_d;
	logic [dtep_pkg::ProdBits-1:0]      prod;
	logic [3:0]                         digit;
	logic                               is_dash;
	logic                               is_digit;

	assign is_dash  = (in_data.ch == dtep_pkg::CharDash);
	assign is_digit = (in_data.ch >= dtep_pkg::CharZero) && (in_data.ch <= dtep_pkg::CharNine);
	// The digit codes run from 0x30, so the low nibble is the digit itself.
	assign digit    = in_data.ch[3:0];

	// Ten times the value plus the digit, by shifts; it cannot exceed four extra bits.
	assign prod = (dtep_pkg::ProdBits'(value_q) << 3) + (dtep_pkg::ProdBits'(value_q) << 1)
		+ dtep_pkg::ProdBits'(digit);

	always_comb begin
		phase_d   = phase_q;
		dash_d    = dash_q;
		value_d   = value_q;
		dash_base = dash_q;
		cmd       = '0;
		cmd.a     = '{depth: dash_q, value: value_q};

		if (is_dash) begin
			// A dash after digits closes the pending node and starts a fresh one.
			if (phase_q == PH_DIGIT) begin
				cmd.a_valid = 1'b1;
				dash_base   = '0;
				value_d     = '0;
			end
			dash_d  = (dash_base == dtep_pkg::DepthMax) ? dash_base
				: dash_base + dtep_pkg::DepthBits'(1);
			phase_d = PH_DASH;
		end else if (is_digit) begin
			value_d = (prod > dtep_pkg::ProdBits'(dtep_pkg::ValueMax)) ? dtep_pkg::ValueMax
				: prod[dtep_pkg::ValueBits-1:0];
			phase_d = PH_DIGIT;
		end

		if (in_data.last) begin
			cmd.b_valid = (phase_d != PH_IDLE);
			cmd.b       = '{depth: dash_d, value: value_d};
			cmd.clear   = 1'b1;
			phase_d     = PH_IDLE;
			dash_d      = '0;
			value_d     = '0;
		end
	end

	assign cmd_push = accept && (cmd.a_valid || cmd.clear);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dash_q  <= '0;
			value_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			dash_q  <= dash_d;
			value_q <= value_d;
		end
	end

endmodule

>>> rtl/dtep_back.sv
// Tree builder: keeps the path stack, numbers nodes and forms the edge records.
module dtep_back #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dtep_pkg::cmd_t        cmd,
	input  logic                  cmd_empty,
	output logic                  cmd_pop,
	output logic                  res_push,
	output dtep_pkg::out_item_t   res,
	input  logic                  res_full
);

	localparam int LenW  = $clog2(STACK_DEPTH + 1);
	localparam int AddrW = $clog2(STACK_DEPTH);
	localparam int CmpW  = (LenW > dtep_pkg::DepthBits) ? LenW : dtep_pkg::DepthBits;

	logic [dtep_pkg::IndexBits-1:0] path_mem [STACK_DEPTH];
	logic                           top_left_q;
	logic [LenW-1:0]                len_q;
	logic [dtep_pkg::IndexBits-1:0] cnt_q;
	logic                           sub_q;

	logic                           sel_a;
	dtep_pkg::node_cmd_t            node;
	logic                           node_go;
	logic                           pop_now;
	logic                           s2_ready;
	logic                           step;
	logic [CmpW-1:0]                len_x;
	logic [CmpW-1:0]                dc_x;
	logic [LenW-1:0]                eff_len;
	logic                           has_parent;
	logic [AddrW-1:0]               top;
	logic [AddrW-1:0]               new_slot;
	logic                           push_ok;
	logic                           cnt_full;
	logic [1:0]                     side;

	logic                           valid_s2;
	dtep_pkg::out_item_t            rec_s2;
	logic                           parent_s2;
	logic [dtep_pkg::IndexBits-1:0] rdata_s2;

	// A node that closes on a dash goes first, an end-of-string node after it.
	assign sel_a    = cmd.a_valid && !sub_q;
	assign node     = sel_a ? cmd.a : cmd.b;
	assign node_go  = sel_a || cmd.b_valid;
	assign pop_now  = !sel_a || !(cmd.b_valid || cmd.clear);
	assign s2_ready = !valid_s2 || !res_full;
	assign step     = !cmd_empty && s2_ready;
	assign cmd_pop  = step && pop_now;

	// The path is cut to the node's depth, never lengthened by it.
	assign len_x      = CmpW'(len_q);
	assign dc_x       = CmpW'(node.depth);
	assign eff_len    = (len_x > dc_x) ? LenW'(dc_x) : len_q;
	assign has_parent = (eff_len != '0);
	assign top        = AddrW'(eff_len - LenW'(1));
	assign new_slot   = AddrW'(eff_len);
	assign push_ok    = (eff_len < LenW'(STACK_DEPTH));
	assign cnt_full   = &cnt_q;

	// Every entry below the top already has its first child above it, so only the top
	// entry can still have a free left side; a node under a cut path always goes right.
	assign side       = !has_parent ? dtep_pkg::SideNone
		: (((eff_len != len_q) || top_left_q) ? dtep_pkg::SideRight : dtep_pkg::SideLeft);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			cnt_q      <= '0;
			sub_q      <= 1'b0;
			top_left_q <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (step) begin
				sub_q <= !pop_now;
				if (!sel_a && cmd.clear) begin
					len_q <= '0;
					cnt_q <= '0;
				end else if (node_go) begin
					if (!cnt_full) begin
						cnt_q <= cnt_q + dtep_pkg::IndexBits'(1);
					end
					len_q      <= push_ok ? eff_len + LenW'(1) : eff_len;
					// A pushed node is a fresh top; otherwise the old top has just taken a child.
					top_left_q <= !push_ok;
				end
			end
			if (s2_ready) begin
				valid_s2 <= step && node_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && node_go) begin
			if (push_ok) begin
				path_mem[new_slot] <= cnt_q;
			end
			rdata_s2  <= path_mem[top];
			parent_s2 <= has_parent;
			rec_s2    <= '{
				node_index:    cnt_q,
				node_value:    node.value,
				node_depth:    node.depth,
				parent_index:  '0,
				side:          side,
				overflow:      cnt_full || !push_ok,
				end_of_string: !sel_a,
				last_of_run:   !sel_a || !cmd.b_valid
			};
		end
	end

	assign res_push = valid_s2 && !res_full;

	always_comb begin
		res              = rec_s2;
		res.parent_index = parent_s2 ? rdata_s2 : '0;
	end

endmodule
